FILE: hdl/tcau_pkg.sv
// Shared types, constants and helpers of the truncated Taylor series unit.
// No dependencies; every other file imports this package.
package tcau_pkg;

    // default storage depth and coefficient format
    localparam int MAX_COEFFS_DEF = 16;
    localparam int COEFF_W        = 32;
    localparam int FRAC_BITS      = 16;
    localparam int ORDER_W        = 4;
    localparam int CNT_W          = ORDER_W + 1;
    localparam int MODE_W         = 3;
    localparam int STATUS_W       = 2;

    // datapath widths
    localparam int PROD_W  = 2 * COEFF_W;
    localparam int ACC_W   = PROD_W + ORDER_W;
    localparam int RND_W   = ACC_W - FRAC_BITS;
    localparam int NUM_W   = RND_W + 1;
    localparam int QMAG_W  = 63;
    localparam int DEN_W   = COEFF_W;
    localparam int DER_W   = COEFF_W + CNT_W + 1;
    localparam int SQ_IN_W = 48;
    localparam int SQ_OUT_W = SQ_IN_W / 2;

    // iteration counts of the shared units
    localparam int DIV_STEPS = QMAG_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);
    localparam int SQ_STEPS  = SQ_IN_W / 2;
    localparam int SQ_CNT_W  = $clog2(SQ_STEPS + 1);

    // operation codes
    localparam logic [MODE_W-1:0] MODE_ADD    = 3'd0;
    localparam logic [MODE_W-1:0] MODE_SUB    = 3'd1;
    localparam logic [MODE_W-1:0] MODE_MUL    = 3'd2;
    localparam logic [MODE_W-1:0] MODE_DIV    = 3'd3;
    localparam logic [MODE_W-1:0] MODE_SQUARE = 3'd4;
    localparam logic [MODE_W-1:0] MODE_SQRT   = 3'd5;
    localparam logic [MODE_W-1:0] MODE_NEG    = 3'd6;
    localparam logic [MODE_W-1:0] MODE_DERIV  = 3'd7;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_ZERO_DIV = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NEG_ROOT = 2'd2;
    localparam logic [STATUS_W-1:0] ST_SAT      = 2'd3;

    // coefficient range and division numerator limit
    localparam logic signed [RND_W-1:0] COEFF_HI =
        $signed((RND_W'(1) << (COEFF_W - 1)) - RND_W'(1));
    localparam logic signed [RND_W-1:0] COEFF_LO = -COEFF_HI - RND_W'(1);
    localparam logic signed [NUM_W-1:0] NUM_LIM =
        $signed((NUM_W'(1) << (QMAG_W - FRAC_BITS)) - NUM_W'(1));

    typedef struct packed {
        logic                      flag;
        logic signed [COEFF_W-1:0] value;
    } sat_res_t;

    typedef struct packed {
        logic              start;
        logic              neg;
        logic [QMAG_W-1:0] num_mag;
        logic [DEN_W-1:0]  den_mag;
    } div_req_t;

    typedef struct packed {
        logic                      done;
        logic                      sat;
        logic signed [COEFF_W-1:0] quot;
    } div_rsp_t;

    typedef struct packed {
        logic               start;
        logic [SQ_IN_W-1:0] radicand;
    } sq_req_t;

    typedef struct packed {
        logic                done;
        logic [SQ_OUT_W-1:0] root;
    } sq_rsp_t;

    // sign extension of a coefficient to the wide datapath
    function automatic logic signed [RND_W-1:0] sext_wide(input logic signed [COEFF_W-1:0] x);
        return {{(RND_W - COEFF_W){x[COEFF_W-1]}}, x};
    endfunction

    // clamp a wide value into the coefficient range
    function automatic sat_res_t sat_coeff(input logic signed [RND_W-1:0] x);
        sat_res_t r;
        if (x > COEFF_HI) begin
            r.flag  = 1'b1;
            r.value = COEFF_HI[COEFF_W-1:0];
        end else if (x < COEFF_LO) begin
            r.flag  = 1'b1;
            r.value = COEFF_LO[COEFF_W-1:0];
        end else begin
            r.flag  = 1'b0;
            r.value = x[COEFF_W-1:0];
        end
        return r;
    endfunction

endpackage

FILE: hdl/tcau_div.sv
// Radix-2 restoring divider, one quotient bit per cycle, with saturation.
// Depends on tcau_pkg.
module tcau_div
    import tcau_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DEN_W-1:0]     rem_reg;
    logic [DEN_W-1:0]     den_reg;
    logic [QMAG_W-1:0]    nsh_reg;
    logic [QMAG_W-1:0]    q_reg;
    logic                 neg_reg;

    logic [DEN_W:0] trial;
    logic [DEN_W:0] diff;
    logic           ge;
    logic           ovf;
    logic [COEFF_W-1:0] q_low;

    // one trial subtraction per cycle
    assign trial = {rem_reg, nsh_reg[QMAG_W-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign ge    = (trial >= {1'b0, den_reg});

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= DIV_CNT_W'(DIV_STEPS);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - DIV_CNT_W'(1);
                if (cnt_reg == DIV_CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= '0;
            den_reg <= req.den_mag;
            nsh_reg <= req.num_mag;
            q_reg   <= '0;
            neg_reg <= req.neg;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            nsh_reg <= {nsh_reg[QMAG_W-2:0], 1'b0};
            q_reg   <= {q_reg[QMAG_W-2:0], ge};
        end
    end

    // signed result with saturation
    assign q_low = q_reg[COEFF_W-1:0];
    assign ovf   = neg_reg ? (q_reg > QMAG_W'(COEFF_HI) + QMAG_W'(1))
                           : (q_reg > QMAG_W'(COEFF_HI));

    always_comb
    begin
        rsp.done = done_reg;
        rsp.sat  = ovf;
        if (ovf)
            rsp.quot = neg_reg ? COEFF_LO[COEFF_W-1:0] : COEFF_HI[COEFF_W-1:0];
        else
            rsp.quot = neg_reg ? -q_low : q_low;
    end

endmodule

FILE: hdl/tcau_isqrt.sv
// Integer square root, two radicand bits per cycle (digit recurrence).
// Depends on tcau_pkg.
module tcau_isqrt
    import tcau_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  sq_req_t req,
    output sq_rsp_t rsp
);

    logic                busy_reg;
    logic                done_reg;
    logic [SQ_CNT_W-1:0] cnt_reg;
    logic [SQ_IN_W-1:0]  x_reg;
    logic [SQ_IN_W-1:0]  r_reg;
    logic [SQ_IN_W-1:0]  bit_reg;

    logic [SQ_IN_W-1:0] r_plus;

    assign r_plus = r_reg + bit_reg;

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= SQ_CNT_W'(SQ_STEPS);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - SQ_CNT_W'(1);
                if (cnt_reg == SQ_CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // one result bit per step
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            x_reg   <= req.radicand;
            r_reg   <= '0;
            bit_reg <= SQ_IN_W'(1) << (SQ_IN_W - 2);
        end
        else if (busy_reg)
        begin
            if (x_reg >= r_plus)
            begin
                x_reg <= x_reg - r_plus;
                r_reg <= (r_reg >> 1) + bit_reg;
            end
            else
            begin
                r_reg <= r_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
    end

    assign rsp.done = done_reg;
    assign rsp.root = r_reg[SQ_OUT_W-1:0];

endmodule

FILE: hdl/taylor_coefficient_arith_unit.sv
// Top level of the truncated Taylor series arithmetic unit: coefficient
// memories, multiply-accumulate sequencer and result output register.
// Depends on tcau_pkg, tcau_div and tcau_isqrt.
//
//   channel | signals                                        | direction
//   --------+------------------------------------------------+----------
//   config  | cfg_wr_en, cfg_wr_data (series_order)          | in
//   input   | in_valid/in_stall: mode, u_coeff, w_coeff,     | in
//           |   load_last                                    |
//   output  | out_valid/out_stall: result_coeff, coeff_index,| out
//           |   status, result_last                          |
//
// After the last loading transfer the sequencer runs the operation over
// n = order+1 coefficients: add/sub/negate/derivative work element-wise
// per coefficient; multiply and square issue k+1 product terms for
// coefficient k (one multiply-accumulate per cycle through the memory read
// ports); divide waits for the bit-serial divider per coefficient, root for
// the square root unit on coefficient 0 and the divider on the rest. Each
// result then passes the EMIT, EMITW and HOLD states, HOLD waiting out
// output stall. Input is stalled from the last transfer until the final
// result transfer. Reset clears control state only; memories need no clearing.
module taylor_coefficient_arith_unit
    import tcau_pkg::*;
#(
    parameter int MAX_COEFFS = MAX_COEFFS_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_wr_en,
    input  logic [ORDER_W-1:0]         cfg_wr_data,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [MODE_W-1:0]          mode,
    input  logic signed [COEFF_W-1:0]  u_coeff,
    input  logic signed [COEFF_W-1:0]  w_coeff,
    input  logic                       load_last,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic signed [COEFF_W-1:0]  result_coeff,
    output logic [ORDER_W-1:0]         coeff_index,
    output logic [STATUS_W-1:0]        status,
    output logic                       result_last
);

    localparam int AW   = (MAX_COEFFS > 1) ? $clog2(MAX_COEFFS) : 1;
    localparam int NCAP = (MAX_COEFFS < (1 << ORDER_W)) ? MAX_COEFFS : (1 << ORDER_W);
    localparam logic [CNT_W-1:0] NCAP_C = CNT_W'(NCAP);

    // sequencer states
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_PRE    = 4'd1;
    localparam logic [3:0] S_PREW   = 4'd2;
    localparam logic [3:0] S_SQRT   = 4'd3;
    localparam logic [3:0] S_ELEM   = 4'd4;
    localparam logic [3:0] S_ELEMW  = 4'd5;
    localparam logic [3:0] S_NUM    = 4'd6;
    localparam logic [3:0] S_NUMW   = 4'd7;
    localparam logic [3:0] S_MAC    = 4'd8;
    localparam logic [3:0] S_DRAIN  = 4'd9;
    localparam logic [3:0] S_FIN    = 4'd10;
    localparam logic [3:0] S_DIVW   = 4'd11;
    localparam logic [3:0] S_EMIT   = 4'd12;
    localparam logic [3:0] S_EMITW  = 4'd13;
    localparam logic [3:0] S_HOLD   = 4'd14;
    localparam logic [3:0] S_KSTART = 4'd15;

    // coefficient memories
    logic signed [COEFF_W-1:0] u_mem [MAX_COEFFS];
    logic signed [COEFF_W-1:0] w_mem [MAX_COEFFS];
    logic signed [COEFF_W-1:0] v_mem [MAX_COEFFS];

    // control registers
    logic [ORDER_W-1:0]  series_order_reg;
    logic [3:0]          state_reg, state_next;
    logic [MODE_W-1:0]   mode_reg, mode_next;
    logic [CNT_W-1:0]    n_reg, n_next;
    logic [CNT_W-1:0]    fill_reg, fill_next;
    logic [CNT_W-1:0]    load_cnt_reg, load_cnt_next;
    logic [CNT_W-1:0]    k_reg, k_next;
    logic [CNT_W-1:0]    j_reg, j_next;
    logic [CNT_W-1:0]    jend_reg, jend_next;
    logic                sat_reg, sat_next;
    logic [STATUS_W-1:0] err_reg, err_next;
    logic                rd_v_reg;
    logic                prd_v_reg;
    logic                out_valid_reg, out_valid_next;

    // payload registers
    logic signed [ACC_W-1:0]   acc_reg, acc_next;
    logic signed [PROD_W-1:0]  prd_reg;
    logic signed [COEFF_W-1:0] unum_reg, unum_next;
    logic signed [COEFF_W:0]   den_reg, den_next;
    logic signed [COEFF_W-1:0] out_coeff_reg, out_coeff_next;
    logic [ORDER_W-1:0]        out_index_reg, out_index_next;
    logic [STATUS_W-1:0]       out_status_reg, out_status_next;
    logic                      out_last_reg, out_last_next;

    // memory read data
    logic signed [COEFF_W-1:0] ua_q, ub_q, wb_q, va_q, vb_q;
    logic                      za_q, zb_q;

    // combinational signals
    logic [CNT_W-1:0]          ord_p1, n_cur, ra_idx, rb_idx, kp1;
    logic [AW-1:0]             ra_addr, rb_addr;
    logic                      za, zb;
    logic                      accept_in, store_en, last_k;
    logic signed [COEFF_W-1:0] ua_m, ub_m, wb_m, mul_a, mul_b;
    logic                      v_we;
    logic [AW-1:0]             v_wa;
    logic signed [COEFF_W-1:0] v_wd;
    logic signed [ACC_W-1:0]   acc_rnd;
    logic signed [RND_W-1:0]   rnd;
    logic signed [NUM_W-1:0]   num, num_c, num_abs;
    logic signed [COEFF_W:0]   den_abs;
    logic signed [DER_W-1:0]   der_prod;
    logic signed [RND_W-1:0]   elem_wide;
    sat_res_t                  conv_sat, elem_sat;
    div_req_t                  div_req;
    div_rsp_t                  div_rsp;
    sq_req_t                   sq_req;
    sq_rsp_t                   sq_rsp;

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            series_order_reg <= ORDER_W'(3);
        else if (cfg_wr_en)
            series_order_reg <= cfg_wr_data;
    end

    // input handshake and load bookkeeping
    assign ord_p1    = {1'b0, series_order_reg} + CNT_W'(1);
    assign n_cur     = (ord_p1 > NCAP_C) ? NCAP_C : ord_p1;
    assign in_stall  = (state_reg != S_IDLE);
    assign accept_in = in_valid && !in_stall;
    assign store_en  = accept_in && (load_cnt_reg < n_cur);

    // loading writes
    always_ff @(posedge clk)
    begin
        if (store_en)
        begin
            u_mem[AW'(load_cnt_reg)] <= u_coeff;
            w_mem[AW'(load_cnt_reg)] <= w_coeff;
        end
    end

    // result writes
    always_ff @(posedge clk)
    begin
        if (v_we)
            v_mem[v_wa] <= v_wd;
    end

    // read addresses by state
    always_comb
    begin
        ra_idx = '0;
        rb_idx = '0;
        case (state_reg)
            S_ELEM:
            begin
                ra_idx = (mode_reg == MODE_DERIV) ? k_reg + CNT_W'(1) : k_reg;
                rb_idx = k_reg;
            end
            S_NUM:  ra_idx = k_reg;
            S_MAC:
            begin
                ra_idx = j_reg;
                rb_idx = k_reg - j_reg;
            end
            S_EMIT: ra_idx = k_reg;
            default:
            begin
                ra_idx = '0;
                rb_idx = '0;
            end
        endcase
    end

    // entries past the loaded count or the order read as zero
    assign za      = (ra_idx >= fill_reg) || (ra_idx >= n_reg);
    assign zb      = (rb_idx >= fill_reg) || (rb_idx >= n_reg);
    assign ra_addr = AW'(ra_idx);
    assign rb_addr = AW'(rb_idx);

    // synchronous memory reads
    always_ff @(posedge clk)
    begin
        ua_q <= u_mem[ra_addr];
        ub_q <= u_mem[rb_addr];
        wb_q <= w_mem[rb_addr];
        va_q <= v_mem[ra_addr];
        vb_q <= v_mem[rb_addr];
        za_q <= za;
        zb_q <= zb;
    end

    assign ua_m = za_q ? '0 : ua_q;
    assign ub_m = zb_q ? '0 : ub_q;
    assign wb_m = zb_q ? '0 : wb_q;

    // multiply operands
    always_comb
    begin
        case (mode_reg)
            MODE_MUL:
            begin
                mul_a = ua_m;
                mul_b = wb_m;
            end
            MODE_SQUARE:
            begin
                mul_a = ua_m;
                mul_b = ub_m;
            end
            MODE_DIV:
            begin
                mul_a = va_q;
                mul_b = wb_m;
            end
            default:
            begin
                mul_a = va_q;
                mul_b = vb_q;
            end
        endcase
    end

    // multiply-accumulate pipeline: read, product, accumulate
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_v_reg  <= 1'b0;
            prd_v_reg <= 1'b0;
        end
        else
        begin
            rd_v_reg  <= (state_reg == S_MAC);
            prd_v_reg <= rd_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        prd_reg <= mul_a * mul_b;
    end

    // rounding of the accumulated sum, half up
    assign acc_rnd  = acc_reg + (ACC_W'(1) <<< (FRAC_BITS - 1));
    assign rnd      = acc_rnd[ACC_W-1:FRAC_BITS];
    assign conv_sat = sat_coeff(rnd);

    // recurrence numerator, clamped
    assign num = {{(NUM_W - COEFF_W){unum_reg[COEFF_W-1]}}, unum_reg} - {rnd[RND_W-1], rnd};
    always_comb
    begin
        if (num > NUM_LIM)
            num_c = NUM_LIM;
        else if (num < -NUM_LIM)
            num_c = -NUM_LIM;
        else
            num_c = num;
    end
    assign num_abs = num_c[NUM_W-1] ? -num_c : num_c;
    assign den_abs = den_reg[COEFF_W] ? -den_reg : den_reg;

    assign div_req.start   = (state_reg == S_FIN) &&
                             ((mode_reg == MODE_DIV) || (mode_reg == MODE_SQRT));
    assign div_req.neg     = num_c[NUM_W-1] ^ den_reg[COEFF_W];
    assign div_req.num_mag = {num_abs[QMAG_W-FRAC_BITS-1:0], {FRAC_BITS{1'b0}}};
    assign div_req.den_mag = den_abs[DEN_W-1:0];

    assign sq_req.start    = (state_reg == S_PREW) && (mode_reg == MODE_SQRT) &&
                             !ua_m[COEFF_W-1] &&
                             !((ua_m == '0) && (n_reg > CNT_W'(1)));
    assign sq_req.radicand = {{(SQ_IN_W - COEFF_W - FRAC_BITS){1'b0}}, ua_m,
                              {FRAC_BITS{1'b0}}};

    tcau_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    tcau_isqrt u_isqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (sq_req),
        .rsp   (sq_rsp)
    );

    // element-wise operations
    assign kp1      = k_reg + CNT_W'(1);
    assign der_prod = ua_m * $signed({1'b0, kp1});
    always_comb
    begin
        case (mode_reg)
            MODE_ADD: elem_wide = sext_wide(ua_m) + sext_wide(wb_m);
            MODE_SUB: elem_wide = sext_wide(ua_m) - sext_wide(wb_m);
            MODE_NEG: elem_wide = -sext_wide(ua_m);
            default:  elem_wide = {{(RND_W - DER_W){der_prod[DER_W-1]}}, der_prod};
        endcase
    end
    assign elem_sat = sat_coeff(elem_wide);

    assign last_k = (k_reg == n_reg - CNT_W'(1));

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        mode_next       = mode_reg;
        n_next          = n_reg;
        fill_next       = fill_reg;
        load_cnt_next   = load_cnt_reg;
        k_next          = k_reg;
        j_next          = j_reg;
        jend_next       = jend_reg;
        sat_next        = sat_reg;
        err_next        = err_reg;
        acc_next        = prd_v_reg ? acc_reg + {{(ACC_W - PROD_W){prd_reg[PROD_W-1]}}, prd_reg}
                                    : acc_reg;
        unum_next       = unum_reg;
        den_next        = den_reg;
        out_valid_next  = out_valid_reg;
        out_coeff_next  = out_coeff_reg;
        out_index_next  = out_index_reg;
        out_status_next = out_status_reg;
        out_last_next   = out_last_reg;
        v_we            = 1'b0;
        v_wa            = AW'(k_reg);
        v_wd            = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept_in)
                begin
                    if (store_en)
                        load_cnt_next = load_cnt_reg + CNT_W'(1);
                    if (load_last)
                    begin
                        fill_next     = store_en ? load_cnt_reg + CNT_W'(1) : load_cnt_reg;
                        load_cnt_next = '0;
                        mode_next     = mode;
                        n_next        = n_cur;
                        k_next        = '0;
                        sat_next      = 1'b0;
                        err_next      = ST_OK;
                        if ((mode == MODE_DIV) || (mode == MODE_SQRT))
                            state_next = S_PRE;
                        else
                            state_next = S_KSTART;
                    end
                end
            end

            // leading coefficients for divide and root
            S_PRE: state_next = S_PREW;
            S_PREW:
            begin
                if (mode_reg == MODE_DIV)
                begin
                    den_next = {wb_m[COEFF_W-1], wb_m};
                    if (wb_m == '0)
                    begin
                        err_next   = ST_ZERO_DIV;
                        k_next     = '0;
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        k_next     = '0;
                        state_next = S_KSTART;
                    end
                end
                else if (ua_m[COEFF_W-1])
                begin
                    err_next   = ST_NEG_ROOT;
                    k_next     = '0;
                    state_next = S_EMIT;
                end
                else if ((ua_m == '0) && (n_reg > CNT_W'(1)))
                begin
                    err_next   = ST_ZERO_DIV;
                    k_next     = '0;
                    state_next = S_EMIT;
                end
                else
                begin
                    state_next = S_SQRT;
                end
            end
            S_SQRT:
            begin
                if (sq_rsp.done)
                begin
                    v_we     = 1'b1;
                    v_wa     = '0;
                    v_wd     = {{(COEFF_W - SQ_OUT_W){1'b0}}, sq_rsp.root};
                    den_next = {{(COEFF_W - SQ_OUT_W){1'b0}}, sq_rsp.root, 1'b0};
                    if (n_reg == CNT_W'(1))
                    begin
                        k_next     = '0;
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        k_next     = CNT_W'(1);
                        state_next = S_KSTART;
                    end
                end
            end

            // dispatch for coefficient k
            S_KSTART:
            begin
                acc_next = '0;
                if ((mode_reg == MODE_MUL) || (mode_reg == MODE_SQUARE))
                begin
                    j_next     = '0;
                    jend_next  = k_reg;
                    state_next = S_MAC;
                end
                else if ((mode_reg == MODE_DIV) || (mode_reg == MODE_SQRT))
                    state_next = S_NUM;
                else
                    state_next = S_ELEM;
            end

            // element-wise result
            S_ELEM: state_next = S_ELEMW;
            S_ELEMW:
            begin
                v_we     = 1'b1;
                v_wd     = elem_sat.value;
                sat_next = sat_reg | elem_sat.flag;
                if (last_k)
                begin
                    k_next     = '0;
                    state_next = S_EMIT;
                end
                else
                begin
                    k_next     = kp1;
                    state_next = S_KSTART;
                end
            end

            // recurrence numerator term
            S_NUM: state_next = S_NUMW;
            S_NUMW:
            begin
                unum_next = ua_m;
                acc_next  = '0;
                if (mode_reg == MODE_DIV)
                begin
                    if (k_reg == '0)
                        state_next = S_FIN;
                    else
                    begin
                        j_next     = '0;
                        jend_next  = k_reg - CNT_W'(1);
                        state_next = S_MAC;
                    end
                end
                else
                begin
                    if (k_reg < CNT_W'(2))
                        state_next = S_FIN;
                    else
                    begin
                        j_next     = CNT_W'(1);
                        jend_next  = k_reg - CNT_W'(1);
                        state_next = S_MAC;
                    end
                end
            end

            // one product term issued per cycle
            S_MAC:
            begin
                if (j_reg == jend_reg)
                    state_next = S_DRAIN;
                else
                    j_next = j_reg + CNT_W'(1);
            end
            S_DRAIN:
            begin
                if (!rd_v_reg && !prd_v_reg)
                    state_next = S_FIN;
            end

            S_FIN:
            begin
                if ((mode_reg == MODE_DIV) || (mode_reg == MODE_SQRT))
                    state_next = S_DIVW;
                else
                begin
                    v_we     = 1'b1;
                    v_wd     = conv_sat.value;
                    sat_next = sat_reg | conv_sat.flag;
                    if (last_k)
                    begin
                        k_next     = '0;
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        k_next     = kp1;
                        state_next = S_KSTART;
                    end
                end
            end
            S_DIVW:
            begin
                if (div_rsp.done)
                begin
                    v_we     = 1'b1;
                    v_wd     = div_rsp.quot;
                    sat_next = sat_reg | div_rsp.sat;
                    if (last_k)
                    begin
                        k_next     = '0;
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        k_next     = kp1;
                        state_next = S_KSTART;
                    end
                end
            end

            // result transfers
            S_EMIT: state_next = S_EMITW;
            S_EMITW:
            begin
                out_valid_next  = 1'b1;
                out_coeff_next  = (err_reg != ST_OK) ? '0 : va_q;
                out_index_next  = k_reg[ORDER_W-1:0];
                out_status_next = (err_reg != ST_OK) ? err_reg : (sat_reg ? ST_SAT : ST_OK);
                out_last_next   = last_k;
                state_next      = S_HOLD;
            end
            S_HOLD:
            begin
                if (!out_stall)
                begin
                    out_valid_next = 1'b0;
                    if (out_last_reg)
                        state_next = S_IDLE;
                    else
                    begin
                        k_next     = kp1;
                        state_next = S_EMIT;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            load_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
            mode_reg      <= MODE_ADD;
            n_reg         <= CNT_W'(1);
            fill_reg      <= '0;
            k_reg         <= '0;
            j_reg         <= '0;
            jend_reg      <= '0;
            sat_reg       <= 1'b0;
            err_reg       <= ST_OK;
        end
        else
        begin
            state_reg     <= state_next;
            load_cnt_reg  <= load_cnt_next;
            out_valid_reg <= out_valid_next;
            mode_reg      <= mode_next;
            n_reg         <= n_next;
            fill_reg      <= fill_next;
            k_reg         <= k_next;
            j_reg         <= j_next;
            jend_reg      <= jend_next;
            sat_reg       <= sat_next;
            err_reg       <= err_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg        <= acc_next;
        unum_reg       <= unum_next;
        den_reg        <= den_next;
        out_coeff_reg  <= out_coeff_next;
        out_index_reg  <= out_index_next;
        out_status_reg <= out_status_next;
        out_last_reg   <= out_last_next;
    end

    assign out_valid    = out_valid_reg;
    assign result_coeff = out_coeff_reg;
    assign coeff_index  = out_index_reg;
    assign status       = out_status_reg;
    assign result_last  = out_last_reg;

`ifndef ASSERT_OFF
    // a result is only offered while the sequencer holds it
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (state_reg == S_HOLD))
        else $error("result offered outside hold state");

    // divider finishes only while the sequencer waits for it
    a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> (state_reg == S_DIVW))
        else $error("divider done while not awaited");

    // load count never passes the coefficient capacity
    a_load_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        load_cnt_reg <= NCAP_C)
        else $error("load count beyond capacity");

    // final result transfer returns the unit to loading
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && result_last) |=> (state_reg == S_IDLE))
        else $error("unit not idle after final result");
`endif

endmodule
